/* src/oets_pkg.sv */
package oets_pkg;

  // Operation codes carried in the op field of an input word
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic               op;
    logic [5:0]         position;
    logic signed [31:0] element_value;
    logic               last_load;
  } in_word_t;

  typedef struct packed {
    logic [5:0]         read_position;
    logic signed [31:0] read_value;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_SORT_WHI
  } state_t;

endpackage

/* src/odd_even_transposition_sorter.sv */
// Channel  Direction  Handshake              Word
// in_      input      in_valid / in_ready    oets_pkg::in_word_t
// out_     output     out_valid / out_ready  oets_pkg::out_word_t
//
// A load writes the store directly. A read goes through the registered store read, then
// the word is handed to the output register, where it waits for out_ready.
// A load with last_load set starts the sort: NUM_ELEMENTS phases, each a read and a
// compare per pair (and two writes when the pair is exchanged), through one comparator
// and the single write port of the element store.
// in_ready is low during the sort and while a read waits for the output register.
// Reset (rst_n, synchronous) clears control state only; the store is not cleared.
module odd_even_transposition_sorter #(
  parameter int NUM_ELEMENTS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  oets_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output oets_pkg::out_word_t  out_data
);

  localparam int AW = $clog2(NUM_ELEMENTS);
  localparam logic [31:0] LAST_IDX = 32'(NUM_ELEMENTS - 1);
  localparam logic [AW:0] N_EXT = (AW + 1)'(NUM_ELEMENTS);
  localparam logic [AW-1:0] LAST_PHASE = AW'(NUM_ELEMENTS - 1);

  // Element store and its registered read ports
  logic [31:0] store_mem [NUM_ELEMENTS];
  logic [31:0] rd_a_r;
  logic [31:0] rd_b_r;

  oets_pkg::state_t state_r, state_nxt;
  logic [AW:0]      lo_r, lo_nxt;
  logic [AW-1:0]    phase_r, phase_nxt;
  logic [5:0]       rd_pos_r, rd_pos_nxt;
  logic             out_valid_r;
  oets_pkg::out_word_t out_data_r;

  logic [5:0]    in_pos;
  logic [AW-1:0] in_addr;
  logic [AW-1:0] lo_addr;
  logic [AW-1:0] hi_addr;
  logic          pair_ok;
  logic          swap;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [AW-1:0] raddr_a;
  logic          out_load;

  // Bound the position to the last entry
  assign in_pos  = ({26'd0, in_data.position} > LAST_IDX) ? 6'(LAST_IDX) : in_data.position;
  assign in_addr = AW'(in_pos);

  assign lo_addr = lo_r[AW-1:0];
  assign hi_addr = lo_addr + 1'b1;
  assign pair_ok = (lo_r + 1'b1) < N_EXT;
  assign swap    = $signed(rd_a_r) > $signed(rd_b_r);

  assign in_ready  = (state_r == oets_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Store: one write port, two read ports with registered data
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_a_r <= store_mem[raddr_a];
      rd_b_r <= store_mem[hi_addr];
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= oets_pkg::ST_IDLE;
      lo_r    <= '0;
      phase_r <= '0;
    end else begin
      state_r <= state_nxt;
      lo_r    <= lo_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_pos_r <= rd_pos_nxt;
  end

  // Output register: fill from a finished read, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.read_position <= rd_pos_r;
      out_data_r.read_value    <= rd_a_r;
    end
  end

  // Next state, store access and compare-exchange steps
  always_comb begin
    state_nxt  = state_r;
    lo_nxt     = lo_r;
    phase_nxt  = phase_r;
    rd_pos_nxt = rd_pos_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = lo_addr;
    mem_wdata  = rd_b_r;
    raddr_a    = lo_addr;
    out_load   = 1'b0;
    unique case (state_r)
      oets_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_data.op == oets_pkg::OP_LOAD) begin
            mem_we    = 1'b1;
            mem_waddr = in_addr;
            mem_wdata = in_data.element_value;
            if (in_data.last_load) begin
              state_nxt = oets_pkg::ST_SORT_RD;
              lo_nxt    = '0;
              phase_nxt = '0;
            end
          end else begin
            mem_re     = 1'b1;
            raddr_a    = in_addr;
            rd_pos_nxt = in_pos;
            state_nxt  = oets_pkg::ST_RD_WAIT;
          end
        end
      end
      oets_pkg::ST_RD_WAIT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = oets_pkg::ST_IDLE;
        end
      end
      oets_pkg::ST_SORT_RD: begin
        if (pair_ok) begin
          mem_re    = 1'b1;
          state_nxt = oets_pkg::ST_SORT_CMP;
        end else if (phase_r == LAST_PHASE) begin
          state_nxt = oets_pkg::ST_IDLE;
        end else begin
          // Advance phase; odd phases start at the pair (1,2)
          phase_nxt = phase_r + 1'b1;
          lo_nxt    = (AW + 1)'(!phase_r[0]);
        end
      end
      oets_pkg::ST_SORT_CMP: begin
        if (swap) begin
          mem_we    = 1'b1;
          mem_waddr = lo_addr;
          mem_wdata = rd_b_r;
          state_nxt = oets_pkg::ST_SORT_WHI;
        end else begin
          lo_nxt    = lo_r + 2'd2;
          state_nxt = oets_pkg::ST_SORT_RD;
        end
      end
      oets_pkg::ST_SORT_WHI: begin
        mem_we    = 1'b1;
        mem_waddr = hi_addr;
        mem_wdata = rd_a_r;
        lo_nxt    = lo_r + 2'd2;
        state_nxt = oets_pkg::ST_SORT_RD;
      end
      default: begin
        state_nxt = oets_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  // A last load always starts the sort
  a_last_starts_sort: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.op == oets_pkg::OP_LOAD) && in_data.last_load
    |=> state_r == oets_pkg::ST_SORT_RD)
    else $error("last load did not start the sort");

  // A new result only comes from a finished read
  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r ##1 out_valid_r |-> $past(state_r) == oets_pkg::ST_RD_WAIT)
    else $error("result word without a read");

  // A compared pair lies inside the store
  a_pair_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == oets_pkg::ST_SORT_CMP |-> (lo_r + 1'b1) < N_EXT)
    else $error("compare-exchange pair beyond the store");

  // No store write from the input side while sorting
  a_no_write_in_sort: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == oets_pkg::ST_SORT_RD || state_r == oets_pkg::ST_SORT_CMP ||
     state_r == oets_pkg::ST_SORT_WHI) |-> !in_ready)
    else $error("input accepted during sort");
`endif

endmodule
